@@ hw/rtl/psd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths and defaults for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int DIFF_W        = COORD_W + 1;     // stop - start, query - start
  localparam int PROD_W        = 2 * DIFF_W;      // one component product
  localparam int LEN_W         = PROD_W;          // squared length, unsigned
  localparam int DOT_W         = PROD_W + 1;      // dot product, signed
  localparam int ERR_W         = COORD_W + 3;     // residual component, signed
  localparam int ESQ_W         = 2 * ERR_W - 3;   // residual component squared
  localparam int SUM_W         = ESQ_W + 1;       // squared distance
  localparam int DIST_W        = 34;
  localparam int TRIAL_W       = SUM_W + 2;

endpackage

@@ hw/rtl/point_segment_distance_3d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_3d
// Fixed-point distance from a query point to a 3D segment, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  in_     | start/stop/query xyz, valid, ready     | request in
//  out_    | distance, degenerate, valid, ready     | result out
//
//  one request per cycle while the output is not stalled; stages in order:
//  differences, products, sums, classify, one quotient bit per stage for t,
//  t*d, residual, square, sum, then one root bit per stage over 34 stages.
//  reset clears the valid bits only.
//  a stall at the output freezes the whole pipeline (ready is shared).
module point_segment_distance_3d
  import psd_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_start_z,
  input  logic signed [COORD_W-1:0] in_stop_x,
  input  logic signed [COORD_W-1:0] in_stop_y,
  input  logic signed [COORD_W-1:0] in_stop_z,
  input  logic signed [COORD_W-1:0] in_query_x,
  input  logic signed [COORD_W-1:0] in_query_y,
  input  logic signed [COORD_W-1:0] in_query_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DIST_W-1:0]         out_distance,
  output logic                      out_degenerate
);

  localparam int NDIV   = FRAC_BITS;
  localparam int NSTAGE = 7 + NDIV + DIST_W + 1;
  localparam int T_W    = FRAC_BITS + 1;
  localparam int TP_W   = T_W + 1 + DIFF_W;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] d;
    logic [2:0][DIFF_W-1:0] w;
    logic [LEN_W-1:0]       len;
    logic [DOT_W-1:0]       rem;
    logic [FRAC_BITS-1:0]   q;
    logic                   degen;
    logic                   zero;
    logic                   full;
  } div_t;

  typedef struct packed {
    logic [SUM_W-1:0]  rem;
    logic [DIST_W-1:0] res;
    logic              degen;
  } root_t;

  logic [NSTAGE-1:0] vld_r;
  logic              adv;

  assign adv       = !vld_r[NSTAGE-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_valid};
    end
  end

  // stage 1: differences
  logic signed [DIFF_W-1:0] d_r [3];
  logic signed [DIFF_W-1:0] w_r [3];
  logic signed [COORD_W-1:0] s_in [3];
  logic signed [COORD_W-1:0] e_in [3];
  logic signed [COORD_W-1:0] q_in [3];

  assign s_in[0] = in_start_x;
  assign s_in[1] = in_start_y;
  assign s_in[2] = in_start_z;
  assign e_in[0] = in_stop_x;
  assign e_in[1] = in_stop_y;
  assign e_in[2] = in_stop_z;
  assign q_in[0] = in_query_x;
  assign q_in[1] = in_query_y;
  assign q_in[2] = in_query_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= DIFF_W'(e_in[i]) - DIFF_W'(s_in[i]);
        w_r[i] <= DIFF_W'(q_in[i]) - DIFF_W'(s_in[i]);
      end
    end
  end

  // stage 2: component products
  logic signed [PROD_W-1:0] dd_r [3];
  logic signed [PROD_W-1:0] dw_r [3];
  logic signed [DIFF_W-1:0] d2_r [3];
  logic signed [DIFF_W-1:0] w2_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dd_r[i] <= d_r[i] * d_r[i];
        dw_r[i] <= d_r[i] * w_r[i];
        d2_r[i] <= d_r[i];
        w2_r[i] <= w_r[i];
      end
    end
  end

  // stage 3: squared length and dot product
  logic [LEN_W-1:0]         len_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic signed [DIFF_W-1:0] d3_r [3];
  logic signed [DIFF_W-1:0] w3_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      len_r <= LEN_W'(dd_r[0]) + LEN_W'(dd_r[1]) + LEN_W'(dd_r[2]);
      dot_r <= DOT_W'(dw_r[0]) + DOT_W'(dw_r[1]) + DOT_W'(dw_r[2]);
      for (int i = 0; i < 3; i++) begin
        d3_r[i] <= d2_r[i];
        w3_r[i] <= w2_r[i];
      end
    end
  end

  // stage 4: classify projection, seed the divider
  div_t dv_r [NDIV+1];
  logic deg_nxt;

  assign deg_nxt = (len_r == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_r[0].d[i] <= d3_r[i];
        dv_r[0].w[i] <= w3_r[i];
      end
      dv_r[0].len   <= len_r;
      dv_r[0].rem   <= dot_r;
      dv_r[0].q     <= '0;
      dv_r[0].degen <= deg_nxt;
      dv_r[0].zero  <= deg_nxt || (dot_r <= 0);
      dv_r[0].full  <= !dot_r[DOT_W-1] && ($unsigned(dot_r) >= {1'b0, len_r});
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [DOT_W-1:0] sh_nxt;
    logic             ge_nxt;
    div_t             dv_nxt;

    always_comb begin
      sh_nxt = {dv_r[k].rem[DOT_W-2:0], 1'b0};
      ge_nxt = (sh_nxt >= {1'b0, dv_r[k].len});
      dv_nxt = dv_r[k];
      dv_nxt.rem = ge_nxt ? sh_nxt - {1'b0, dv_r[k].len} : sh_nxt;
      dv_nxt.q   = {dv_r[k].q[FRAC_BITS-2:0], ge_nxt};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1] <= dv_nxt;
      end
    end
  end

  // t * d
  logic [T_W-1:0]         t_nxt;
  logic signed [TP_W-1:0] tp_r [3];
  logic signed [DIFF_W-1:0] w4_r [3];
  logic                   deg4_r;
  div_t                   dq;

  assign dq = dv_r[NDIV];

  always_comb begin
    priority if (dq.zero) begin
      t_nxt = '0;
    end else if (dq.full) begin
      t_nxt = T_W'(1) << FRAC_BITS;
    end else begin
      t_nxt = {1'b0, dq.q};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        tp_r[i] <= $signed({1'b0, t_nxt}) * $signed(dq.d[i]);
        w4_r[i] <= $signed(dq.w[i]);
      end
      deg4_r <= dq.degen;
    end
  end

  // residual, floor on the dropped fraction
  logic signed [ERR_W-1:0] e_r [3];
  logic signed [TP_W-1:0]  tps_nxt [3];
  logic                    deg5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tps_nxt[i] = tp_r[i] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e_r[i] <= ERR_W'(w4_r[i]) - tps_nxt[i][ERR_W-1:0];
      end
      deg5_r <= deg4_r;
    end
  end

  // residual squares
  logic [ESQ_W-1:0]          esq_r [3];
  logic signed [2*ERR_W-1:0] esq_nxt [3];
  logic                      deg6_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      esq_nxt[i] = e_r[i] * e_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        esq_r[i] <= esq_nxt[i][ESQ_W-1:0];
      end
      deg6_r <= deg5_r;
    end
  end

  // squared distance, seeds the root
  root_t rt_r [DIST_W+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_r[0].rem   <= SUM_W'(esq_r[0]) + SUM_W'(esq_r[1]) + SUM_W'(esq_r[2]);
      rt_r[0].res   <= '0;
      rt_r[0].degen <= deg6_r;
    end
  end

  // integer square root, one result bit per stage from the top
  for (genvar j = 0; j < DIST_W; j++) begin : g_root
    localparam int B = DIST_W - 1 - j;
    logic [TRIAL_W-1:0] trial_nxt;
    logic               fit_nxt;
    root_t              rt_nxt;

    always_comb begin
      trial_nxt = (TRIAL_W'(rt_r[j].res) << (B + 1)) + (TRIAL_W'(1) << (2 * B));
      fit_nxt   = (trial_nxt <= TRIAL_W'(rt_r[j].rem));
      rt_nxt    = rt_r[j];
      if (fit_nxt) begin
        rt_nxt.rem    = rt_r[j].rem - trial_nxt[SUM_W-1:0];
        rt_nxt.res[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_r[j+1] <= rt_nxt;
      end
    end
  end

  assign out_distance   = rt_r[DIST_W].res;
  assign out_degenerate = rt_r[DIST_W].degen;

  // pipeline holds still under a stall
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid bits moved during stall");

  // partial remainder stays below the squared length for in-range projections
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3+NDIV] && !dq.zero && !dq.full) |-> (dq.rem < {1'b0, dq.len}))
    else $error("divider remainder out of range");

  // root remainder bounded by twice the root
  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (rt_r[DIST_W].rem <= {rt_r[DIST_W].res, 1'b0}))
    else $error("square root remainder out of range");

endmodule
